// ===== sv/geocentric_geodetic_latitude_convert_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the latitude convert core
// Shared property forms used by the checker file gglc_checker.sv.
// ----------------------------------------------------------------------------
`ifndef GEOCENTRIC_GEODETIC_LATITUDE_CONVERT_CORE_ASSERT_SVH
`define GEOCENTRIC_GEODETIC_LATITUDE_CONVERT_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define GGLC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define GGLC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/gglc_pkg.sv =====
// ----------------------------------------------------------------------------
// gglc_pkg
// Types, widths and CORDIC angle constants for the latitude convert core.
// ----------------------------------------------------------------------------
`default_nettype none

package gglc_pkg;

  localparam int WORK_BITS       = 60;
  localparam int ANGLE_FRAC_BITS = 30;
  localparam int ROUND_SHIFT     = WORK_BITS - ANGLE_FRAC_BITS;
  localparam int XY_W            = 56;
  localparam int Z_W             = 64;
  localparam int LAT_W           = 32;
  localparam int LON_W           = 33;
  localparam int ALT_W           = 38;
  localparam int FLAT_W          = 32;
  localparam int K_W             = 33;
  localparam int TDATA_W         = 104;

  localparam logic [FLAT_W-1:0] FLAT_RESET = 32'd14400212;
  localparam logic signed [XY_W-1:0] START_MAG = XY_W'(64'd1 << 50);

  // working vector of one CORDIC cell
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  // fields that ride along the chain
  typedef struct packed {
    logic                    op;
    logic                    zero;
    logic signed [LON_W-1:0] lon;
    logic signed [ALT_W-1:0] alt;
  } side_t;

  // restoring divide, elaboration time only
  function automatic logic [63:0] udiv64(input logic [63:0] num,
                                         input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(1/n) at 2^-60 from the truncated alternating series
  function automatic logic signed [63:0] atan_inv(input logic [63:0] n);
    logic [63:0]        p;
    logic [63:0]        d;
    logic [63:0]        t;
    logic signed [63:0] sum;
    logic               neg;
    p   = udiv64(64'd1 << WORK_BITS, n);
    d   = 64'd1;
    sum = '0;
    neg = 1'b0;
    for (int j = 0; j < 32; j++) begin
      if (p != '0) begin
        t   = udiv64(p, d);
        sum = neg ? sum - signed'(t) : sum + signed'(t);
        neg = !neg;
        d   = d + 64'd2;
        p   = udiv64(udiv64(p, n), n);
      end
    end
    return sum;
  endfunction

  // step angle of a stage; stage 0 is pi/4 built as atan(1/2)+atan(1/3)
  function automatic logic signed [63:0] cordic_atan(input int stage);
    logic signed [63:0] a;
    if (stage == 0) begin
      a = atan_inv(64'd2) + atan_inv(64'd3);
    end else begin
      a = atan_inv(64'd1 << stage);
    end
    return a;
  endfunction

  localparam logic signed [Z_W-1:0] HALF_PI_W = signed'(cordic_atan(0) <<< 1);
  localparam logic signed [Z_W-1:0] LAT_LIMIT = HALF_PI_W >>> ROUND_SHIFT;

endpackage

`default_nettype wire

// ===== sv/gglc_rot_cell.sv =====
// ----------------------------------------------------------------------------
// gglc_rot_cell
// One rotation-mode CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gglc_rot_cell import gglc_pkg::*; #(
  parameter int STAGE = 0
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    ce,
  input  wire logic    in_valid,
  input  wire cordic_t in_data,
  input  wire side_t   in_side,
  output logic         out_valid,
  output cordic_t      out_data,
  output side_t        out_side
);

  localparam logic signed [Z_W-1:0] ANGLE = Z_W'(cordic_atan(STAGE));

  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  cordic_t                data_next;

  // drive residual angle toward zero
  always_comb begin
    xs = in_data.x >>> STAGE;
    ys = in_data.y >>> STAGE;
    if (in_data.z >= 0) begin
      data_next.x = in_data.x - ys;
      data_next.y = in_data.y + xs;
      data_next.z = in_data.z - ANGLE;
    end else begin
      data_next.x = in_data.x + ys;
      data_next.y = in_data.y - xs;
      data_next.z = in_data.z + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_data <= data_next;
      out_side <= in_side;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gglc_vec_cell.sv =====
// ----------------------------------------------------------------------------
// gglc_vec_cell
// One vectoring-mode CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gglc_vec_cell import gglc_pkg::*; #(
  parameter int STAGE = 0
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    ce,
  input  wire logic    in_valid,
  input  wire cordic_t in_data,
  input  wire side_t   in_side,
  output logic         out_valid,
  output cordic_t      out_data,
  output side_t        out_side
);

  localparam logic signed [Z_W-1:0] ANGLE = Z_W'(cordic_atan(STAGE));

  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  cordic_t                data_next;

  // drive y toward zero, accumulate the angle
  always_comb begin
    xs = in_data.x >>> STAGE;
    ys = in_data.y >>> STAGE;
    if (in_data.y >= 0) begin
      data_next.x = in_data.x + ys;
      data_next.y = in_data.y - xs;
      data_next.z = in_data.z + ANGLE;
    end else begin
      data_next.x = in_data.x - ys;
      data_next.y = in_data.y + xs;
      data_next.z = in_data.z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_data <= data_next;
      out_side <= in_side;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gglc_scale.sv =====
// ----------------------------------------------------------------------------
// gglc_scale
// Two-stage scaling of cos or sin by k = 1 - e^2, magnitude truncated.
// ----------------------------------------------------------------------------
`default_nettype none

module gglc_scale import gglc_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           ce,
  input  wire logic [K_W-1:0] k,
  input  wire logic           in_valid,
  input  wire cordic_t        in_data,
  input  wire side_t          in_side,
  output logic                out_valid,
  output cordic_t             out_data,
  output side_t               out_side
);

  localparam int HI_W = XY_W - 32;

  // stage A: pick operand, split magnitude, two partial products
  logic signed [XY_W-1:0] xc;
  logic signed [XY_W-1:0] sel;
  logic signed [XY_W-1:0] other_a;
  logic                   neg_a;
  logic [XY_W-1:0]        mag;

  logic                    valid_a;
  side_t                   side_a;
  logic signed [XY_W-1:0]  other;
  logic                    neg;
  logic [HI_W+K_W-1:0]     prod_hi;
  logic [32+K_W-1:0]       prod_lo;

  always_comb begin
    // small negative cosine near the poles counts as zero
    xc      = (in_data.x < 0) ? '0 : in_data.x;
    sel     = in_side.op ? in_data.y : xc;
    other_a = in_side.op ? xc : in_data.y;
    neg_a   = sel < 0;
    mag     = neg_a ? XY_W'(-sel) : XY_W'(sel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (ce) begin
      valid_a <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      side_a  <= in_side;
      other   <= other_a;
      neg     <= neg_a;
      prod_hi <= mag[XY_W-1:32] * k;
      prod_lo <= mag[31:0] * k;
    end
  end

  // stage B: sum partials, restore sign, flag the zero vector
  logic [XY_W-1:0]        r;
  logic signed [XY_W-1:0] scaled;
  cordic_t                data_next;
  side_t                  side_next;

  always_comb begin
    r           = XY_W'(prod_hi) + XY_W'(prod_lo[32+K_W-1:32]);
    scaled      = neg ? -signed'(r) : signed'(r);
    data_next.x = side_a.op ? other : scaled;
    data_next.y = side_a.op ? scaled : other;
    data_next.z = '0;
    side_next      = side_a;
    side_next.zero = (data_next.x == '0) && (data_next.y == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_data <= data_next;
      out_side <= side_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/geocentric_geodetic_latitude_convert_core.sv =====
// Data path: input register, unrolled rotation CORDIC cell chain, k scaling,
//   unrolled vectoring CORDIC cell chain, rounding register, output buffer.
// Throughput: one transaction per cycle while an output entry is free; the
//   two-entry output buffer lets the chain keep taking input while one result waits.
// Reset: clears all valid flags and the output buffer, restores WGS84
//   flattening; k follows a flattening write via the flat_d/flat_sq registers.
// ----------------------------------------------------------------------------
// geocentric_geodetic_latitude_convert_core
// Geocentric/geodetic latitude conversion by rotation CORDIC, k scaling and
// vectoring CORDIC; longitude and altitude pass through.
// ----------------------------------------------------------------------------
`default_nettype none

module geocentric_geodetic_latitude_convert_core import gglc_pkg::*; #(
  parameter int CORDIC_STAGES = 30
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration: flattening, units of 2^-32
  input  wire logic               cfg_we,
  input  wire logic [FLAT_W-1:0]  cfg_wdata,
  // input stream
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // latitude_in[31:0], longitude_in[64:32], altitude_in[102:65], zero pad
  input  wire logic [TDATA_W-1:0] s_axis_tdata,
  // op
  input  wire logic               s_axis_tuser,
  // output stream
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // latitude_out[31:0], longitude_out[64:32], altitude_out[102:65], zero pad
  output logic [TDATA_W-1:0]      m_axis_tdata
);

  logic ce;
  logic skid_valid;

  // chain advances unless both output entries are occupied
  assign ce            = !(m_axis_tvalid && skid_valid);
  assign s_axis_tready = ce;

  // flattening register and k = 2^32 - 2f + ceil(f^2 / 2^32)
  logic [FLAT_W-1:0]   flat;
  logic [FLAT_W-1:0]   flat_d;
  logic [2*FLAT_W-1:0] flat_sq;
  logic [K_W+1:0]      k_sum;
  logic [K_W-1:0]      k;

  always_ff @(posedge clk) begin
    if (rst) begin
      flat <= FLAT_RESET;
    end else if (cfg_we) begin
      flat <= cfg_wdata;
    end
  end

  always_comb begin
    k_sum = (35'd1 << 32) - 35'({flat_d, 1'b0}) + 35'(flat_sq[63:32])
          + 35'(flat_sq[31:0] != '0);
  end

  always_ff @(posedge clk) begin
    flat_d  <= flat;
    flat_sq <= flat * flat;
    k       <= K_W'(k_sum);
  end

  // input stage: saturate latitude and move it to working units
  logic signed [LAT_W-1:0] lat_in;
  logic signed [Z_W-1:0]   lat_ext;
  logic signed [Z_W-1:0]   lat_sat;
  cordic_t                 in_data;
  side_t                   in_side;

  always_comb begin
    lat_in  = signed'(s_axis_tdata[LAT_W-1:0]);
    lat_ext = Z_W'(lat_in);
    if (lat_ext > LAT_LIMIT) begin
      lat_sat = LAT_LIMIT;
    end else if (lat_ext < -LAT_LIMIT) begin
      lat_sat = -LAT_LIMIT;
    end else begin
      lat_sat = lat_ext;
    end
    in_data.x    = START_MAG;
    in_data.y    = '0;
    in_data.z    = lat_sat <<< ROUND_SHIFT;
    in_side.op   = s_axis_tuser;
    in_side.zero = 1'b0;
    in_side.lon  = signed'(s_axis_tdata[LAT_W+LON_W-1:LAT_W]);
    in_side.alt  = signed'(s_axis_tdata[LAT_W+LON_W+ALT_W-1:LAT_W+LON_W]);
  end

  logic    rot_valid [CORDIC_STAGES+1];
  cordic_t rot_data  [CORDIC_STAGES+1];
  side_t   rot_side  [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_valid[0] <= 1'b0;
    end else if (ce) begin
      rot_valid[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rot_data[0] <= in_data;
      rot_side[0] <= in_side;
    end
  end

  // rotation chain: (x, y) -> gain * (cos, sin)
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    gglc_rot_cell #(.STAGE(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ce        (ce),
      .in_valid  (rot_valid[i]),
      .in_data   (rot_data[i]),
      .in_side   (rot_side[i]),
      .out_valid (rot_valid[i+1]),
      .out_data  (rot_data[i+1]),
      .out_side  (rot_side[i+1])
    );
  end

  logic    vec_valid [CORDIC_STAGES+1];
  cordic_t vec_data  [CORDIC_STAGES+1];
  side_t   vec_side  [CORDIC_STAGES+1];

  // multiply cos or sin by k
  gglc_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .k         (k),
    .in_valid  (rot_valid[CORDIC_STAGES]),
    .in_data   (rot_data[CORDIC_STAGES]),
    .in_side   (rot_side[CORDIC_STAGES]),
    .out_valid (vec_valid[0]),
    .out_data  (vec_data[0]),
    .out_side  (vec_side[0])
  );

  // vectoring chain: z -> atan2(y, x)
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    gglc_vec_cell #(.STAGE(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ce        (ce),
      .in_valid  (vec_valid[i]),
      .in_data   (vec_data[i]),
      .in_side   (vec_side[i]),
      .out_valid (vec_valid[i+1]),
      .out_data  (vec_data[i+1]),
      .out_side  (vec_side[i+1])
    );
  end

  // round half up to output units, clamp to +-pi/2
  logic signed [Z_W-1:0] z_src;
  logic signed [Z_W-1:0] z_rnd;
  logic signed [Z_W-1:0] z_sat;
  logic [TDATA_W-1:0]    fin_tdata_next;
  logic                  fin_valid;
  logic [TDATA_W-1:0]    fin_tdata;

  always_comb begin
    z_src = vec_side[CORDIC_STAGES].zero ? '0 : vec_data[CORDIC_STAGES].z;
    z_rnd = (z_src + (Z_W'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    if (z_rnd > LAT_LIMIT) begin
      z_sat = LAT_LIMIT;
    end else if (z_rnd < -LAT_LIMIT) begin
      z_sat = -LAT_LIMIT;
    end else begin
      z_sat = z_rnd;
    end
    fin_tdata_next = {1'b0, vec_side[CORDIC_STAGES].alt,
                      vec_side[CORDIC_STAGES].lon, z_sat[LAT_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (ce) begin
      fin_valid <= vec_valid[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      fin_tdata <= fin_tdata_next;
    end
  end

  // two-entry output buffer: output register plus skid entry
  logic               push;
  logic [TDATA_W-1:0] skid_tdata;

  assign push = ce && fin_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      if (skid_valid) begin
        m_axis_tvalid <= 1'b1;
        skid_valid    <= push;
      end else begin
        m_axis_tvalid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_axis_tvalid || m_axis_tready) begin
      if (skid_valid) begin
        m_axis_tdata <= skid_tdata;
        skid_tdata   <= fin_tdata;
      end else begin
        m_axis_tdata <= fin_tdata;
      end
    end else if (push) begin
      skid_tdata <= fin_tdata;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gglc_checker.sv =====
// ----------------------------------------------------------------------------
// gglc_checker
// Port-level checks for the latitude convert core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "geocentric_geodetic_latitude_convert_core_assert.svh"

module gglc_checker import gglc_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               s_axis_tvalid,
  input wire logic               s_axis_tready,
  input wire logic               m_axis_tvalid,
  input wire logic               m_axis_tready,
  input wire logic [TDATA_W-1:0] m_axis_tdata
);

  logic signed [Z_W-1:0] lat_out;

  assign lat_out = Z_W'(signed'(m_axis_tdata[LAT_W-1:0]));

  // a stalled result holds its data
  `GGLC_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")

  // input backpressure only when a result is waiting
  `GGLC_ASSERT_NOW(a_ready_stall, clk, rst, !s_axis_tready, m_axis_tvalid, "input stalled with empty output")

  // converted latitude stays within +-pi/2
  `GGLC_ASSERT_NOW(a_lat_range, clk, rst, m_axis_tvalid, (lat_out <= LAT_LIMIT) && (lat_out >= -LAT_LIMIT), "latitude out of range")

  // nothing leaves right after reset
  `GGLC_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), !m_axis_tvalid && s_axis_tready, "output not empty after reset")

endmodule

bind geocentric_geodetic_latitude_convert_core gglc_checker u_gglc_checker (.*);

`default_nettype wire
